[hw/rtl/oudng_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oudng_pkg
// Shared constants, fixed-point widths and controller command types for the
// drift noise generator.
// ----------------------------------------------------------------------------
package oudng_pkg;

    // Fraction bits of the internal drift level
    localparam int FRACTION_BITS = 20;
    localparam int OUT_FRACTION  = 20;

    // Level holds +-4.0 exactly: magnitude needs FRACTION_BITS + 3 bits
    localparam int LEVEL_W = FRACTION_BITS + 4;
    localparam int SUM_W   = LEVEL_W + 2;
    localparam int DRIFT_W = 24;

    // Shared multiplier: signed A by signed B
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int NOISE_SHIFT = 40 - FRACTION_BITS;
    localparam int OUT_RSHIFT  = (FRACTION_BITS >= OUT_FRACTION) ?
                                 (FRACTION_BITS - OUT_FRACTION) : 0;
    localparam int OUT_LSHIFT  = (FRACTION_BITS < OUT_FRACTION) ?
                                 (OUT_FRACTION - FRACTION_BITS) : 0;

    localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(1) <<< (FRACTION_BITS + 2);
    localparam logic signed [SUM_W-1:0] SAT_LOW  = -SAT_HIGH;

    localparam logic [20:0] LCG_MUL        = 21'd1664525;
    localparam logic [31:0] LCG_ADD        = 32'd1013904223;
    localparam logic [24:0] ONE_Q24        = 25'h100_0000;
    localparam logic [15:0] SEVEN_TENTHS   = 16'd45875;
    localparam logic [16:0] FACTOR_ONE     = 17'h1_0000;
    localparam logic [15:0] FACTOR_FULL    = 16'hFFFF;
    localparam logic [17:0] NOISE_OFFSET   = 18'd65535;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED   = 2'd2;

    localparam logic [23:0] BASE_ALPHA_RESET = 24'd16761685;
    localparam logic [23:0] BASE_BETA_RESET  = 24'd704643;
    localparam logic [31:0] RNG_SEED_RESET   = 32'd0;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_ALPHA_GAP,
        MUL_LCG,
        MUL_ALPHA_SCALE,
        MUL_BETA,
        MUL_ALPHA_LEVEL,
        MUL_BETA_NOISE,
        MUL_OUTPUT
    } mul_sel_t;

    // Destination of the registered product
    typedef enum logic [2:0] {
        WB_NONE,
        WB_GAP,
        WB_RNG1,
        WB_ALPHA,
        WB_RNG2,
        WB_BETA,
        WB_ACC,
        WB_LEVEL
    } wb_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
        logic     out_load;
    } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/oudng_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oudng_ctrl
// Sequencer for the shared multiplier and the output register handshake.
// ----------------------------------------------------------------------------
module oudng_ctrl
    import oudng_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic action,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALPHA_GAP,
        S_GAP_WB,
        S_RNG1_WB,
        S_ALPHA_WB,
        S_RNG2_WB,
        S_BETA_WB,
        S_ACC_WB,
        S_LEVEL_WB,
        S_OUT_MUL,
        S_OUT_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.mul_sel  = MUL_OUTPUT;
        cmd.wb_sel   = WB_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = action ? S_OUT_WRITE : S_ALPHA_GAP;
                end
            end
            S_ALPHA_GAP:
            begin
                cmd.mul_sel = MUL_ALPHA_GAP;
                state_next  = S_GAP_WB;
            end
            S_GAP_WB:
            begin
                cmd.wb_sel  = WB_GAP;
                cmd.mul_sel = MUL_LCG;
                state_next  = S_RNG1_WB;
            end
            S_RNG1_WB:
            begin
                cmd.wb_sel  = WB_RNG1;
                cmd.mul_sel = MUL_ALPHA_SCALE;
                state_next  = S_ALPHA_WB;
            end
            S_ALPHA_WB:
            begin
                cmd.wb_sel  = WB_ALPHA;
                cmd.mul_sel = MUL_LCG;
                state_next  = S_RNG2_WB;
            end
            S_RNG2_WB:
            begin
                cmd.wb_sel  = WB_RNG2;
                cmd.mul_sel = MUL_BETA;
                state_next  = S_BETA_WB;
            end
            S_BETA_WB:
            begin
                cmd.wb_sel  = WB_BETA;
                cmd.mul_sel = MUL_ALPHA_LEVEL;
                state_next  = S_ACC_WB;
            end
            S_ACC_WB:
            begin
                cmd.wb_sel  = WB_ACC;
                cmd.mul_sel = MUL_BETA_NOISE;
                state_next  = S_LEVEL_WB;
            end
            S_LEVEL_WB:
            begin
                cmd.wb_sel = WB_LEVEL;
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                state_next = S_OUT_WRITE;
            end
            S_OUT_WRITE:
            begin
                // Product keeps recomputing the same value while the slot is full
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[hw/rtl/oudng_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oudng_datapath
// Configuration registers, generator and drift state, one shared multiplier
// with a registered product, and the output register.
// ----------------------------------------------------------------------------
module oudng_datapath
    import oudng_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    input  wire logic                   action,
    input  wire logic [15:0]            amount,
    input  wire logic [15:0]            age,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]            cfg_data,
    output logic signed [DRIFT_W-1:0]   drift
);

    // Full scale code counts as exactly 1.0
    function automatic logic [16:0] as_factor(input logic [15:0] v);
        return (v == FACTOR_FULL) ? FACTOR_ONE : {1'b0, v};
    endfunction

    logic [23:0]                base_alpha_reg, base_alpha_next;
    logic [23:0]                base_beta_reg, base_beta_next;
    logic [31:0]                rng_reg, rng_next;
    logic signed [LEVEL_W-1:0]  level_reg, level_next;

    logic                       action_reg;
    logic [16:0]                amt_reg;
    logic [16:0]                agef_reg;
    logic [24:0]                gap_reg;
    logic [24:0]                alpha_reg;
    logic [15:0]                u1_reg;
    logic signed [17:0]         noise_reg;
    logic [25:0]                beta_reg;
    logic signed [LEVEL_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DRIFT_W-1:0]  drift_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic [24:0]                one_minus_alpha;
    logic [31:0]                lcg_value;
    logic signed [17:0]         noise_value;
    logic [43:0]                beta_triple;
    logic signed [SUM_W-1:0]    acc_ext;
    logic signed [SUM_W-1:0]    noise_term;
    logic signed [SUM_W-1:0]    level_sum;
    logic signed [LEVEL_W-1:0]  level_sat;
    logic signed [DRIFT_W-1:0]  drift_value;

    always_comb
    begin
        one_minus_alpha = ONE_Q24 - {1'b0, base_alpha_reg};
        unique case (cmd.mul_sel)
            MUL_ALPHA_GAP:
            begin
                mul_a = MUL_A_W'(one_minus_alpha);
                mul_b = MUL_B_W'(agef_reg);
            end
            MUL_LCG:
            begin
                mul_a = MUL_A_W'(rng_reg);
                mul_b = MUL_B_W'(LCG_MUL);
            end
            MUL_ALPHA_SCALE:
            begin
                mul_a = MUL_A_W'(gap_reg);
                mul_b = MUL_B_W'(SEVEN_TENTHS);
            end
            MUL_BETA:
            begin
                mul_a = MUL_A_W'(base_beta_reg);
                mul_b = MUL_B_W'(agef_reg);
            end
            MUL_ALPHA_LEVEL:
            begin
                mul_a = MUL_A_W'(level_reg);
                mul_b = MUL_B_W'(alpha_reg);
            end
            MUL_BETA_NOISE:
            begin
                mul_a = MUL_A_W'(noise_reg);
                mul_b = MUL_B_W'(beta_reg);
            end
            MUL_OUTPUT:
            begin
                mul_a = MUL_A_W'(level_reg);
                mul_b = MUL_B_W'(amt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Post-processing of the registered product
    always_comb
    begin
        lcg_value   = prod_reg[31:0] + LCG_ADD;
        noise_value = {2'b00, u1_reg} + {2'b00, lcg_value[23:8]} - NOISE_OFFSET;
        beta_triple = {1'b0, prod_reg[41:0], 1'b0} + {2'b00, prod_reg[41:0]};
        acc_ext     = SUM_W'(acc_reg);
        noise_term  = prod_reg[NOISE_SHIFT +: SUM_W];
        level_sum   = acc_ext + noise_term;
        if (level_sum > SAT_HIGH)
        begin
            level_sat = SAT_HIGH[LEVEL_W-1:0];
        end
        else if (level_sum < SAT_LOW)
        begin
            level_sat = SAT_LOW[LEVEL_W-1:0];
        end
        else
        begin
            level_sat = level_sum[LEVEL_W-1:0];
        end
        drift_value = prod_reg[16 + OUT_RSHIFT +: DRIFT_W] << OUT_LSHIFT;
    end

    always_comb
    begin
        base_alpha_next = base_alpha_reg;
        base_beta_next  = base_beta_reg;
        rng_next        = rng_reg;
        level_next      = level_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE_ALPHA: base_alpha_next = cfg_data[23:0];
                CFG_BASE_BETA:  base_beta_next  = cfg_data[23:0];
                CFG_RNG_SEED:   rng_next        = cfg_data;
                default:        ;
            endcase
        end
        else if (cmd.wb_sel == WB_RNG1 || cmd.wb_sel == WB_RNG2)
        begin
            rng_next = lcg_value;
        end
        if (cmd.wb_sel == WB_LEVEL)
        begin
            level_next = level_sat;
        end
        else if (cmd.out_load && action_reg)
        begin
            level_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_alpha_reg <= BASE_ALPHA_RESET;
            base_beta_reg  <= BASE_BETA_RESET;
            rng_reg        <= RNG_SEED_RESET;
            level_reg      <= '0;
        end
        else
        begin
            base_alpha_reg <= base_alpha_next;
            base_beta_reg  <= base_beta_next;
            rng_reg        <= rng_next;
            level_reg      <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            action_reg <= action;
            amt_reg    <= as_factor(amount);
            agef_reg   <= as_factor(age);
        end
        case (cmd.wb_sel)
            WB_GAP:   gap_reg   <= prod_reg[40:16];
            WB_RNG1:  u1_reg    <= lcg_value[23:8];
            WB_ALPHA: alpha_reg <= {1'b0, base_alpha_reg} + prod_reg[40:16];
            WB_RNG2:  noise_reg <= noise_value;
            WB_BETA:  beta_reg  <= {2'b00, base_beta_reg} + beta_triple[42:17];
            WB_ACC:   acc_reg   <= prod_reg[24 +: LEVEL_W];
            default:  ;
        endcase
        if (cmd.out_load)
        begin
            drift_reg <= action_reg ? '0 : drift_value;
        end
    end

    assign drift = drift_reg;

endmodule
`default_nettype wire

[hw/rtl/ou_drift_noise_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ou_drift_noise_generator
// Leaky drift state driven by triangular LCG noise, scaled by a depth input.
//
// Input channel (in_valid/in_ready) carries action, amount and age. Action 0
// processes one sample, action 1 clears the drift level and returns 0.
// Output channel (out_valid/out_ready) carries drift, signed Q3.20.
// Configuration channel (cfg_valid/cfg_ready) writes base_alpha (index 0),
// base_beta (index 1) and rng_seed (index 2); cfg_ready is always high and a
// seed write reloads the generator. Write it only while no sample is in work.
// A sample transfer runs through the states S_ALPHA_GAP to S_OUT_WRITE before
// it lands in the output register; a clear goes straight to S_OUT_WRITE. A
// sample takes eight passes through the single shared multiplier plus
// write-back and output steps.
// The input side opens again as soon as the result sits in the output
// register, so a stalled receiver holds at most one finished result and
// stops the next sample only at its output step.
// Reset loads the register defaults, sets the generator to the seed reset
// value and clears the drift level; both channels come up empty.
// ----------------------------------------------------------------------------
module ou_drift_noise_generator
    import oudng_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    input  wire logic [15:0]            amount,
    input  wire logic [15:0]            age,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [DRIFT_W-1:0]   drift,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]            cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    oudng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    oudng_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .amount    (amount),
        .age       (age),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .drift     (drift)
    );

endmodule
`default_nettype wire

[hw/rtl/oudng_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oudng_props
// Port-level checks of sequencing and output behavior, bound to the top level.
// ----------------------------------------------------------------------------
module oudng_props
    import oudng_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   action,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic signed [DRIFT_W-1:0] drift
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drift))
        else $error("stalled result changed or dropped");

    // One sample at a time: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A clear with a free output slot passes S_OUT_WRITE without a stall and returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action && !out_valid |->
            ##2 (out_valid && drift == DRIFT_W'(0)))
        else $error("clear did not return zero on time");

    // A new result appears only as the sequencer goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result written while sequencer busy");

endmodule

bind ou_drift_noise_generator oudng_props u_checker (.*);
`default_nettype wire
